@@ rtl/core/lts_pkg.sv @@
// shared types and constants for the lit texture block shader
package lts_pkg;

  localparam int SHADE_LEVELS = 64;
  localparam int TABLE_DEPTH  = SHADE_LEVELS * 256;
  localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
  localparam int LEVEL_W      = $clog2(SHADE_LEVELS);
  localparam int LIGHT_W      = 18;
  localparam int CORNER_W     = 14;
  localparam int OFIFO_DEPTH  = 4;
  localparam int OFIFO_AW     = $clog2(OFIFO_DEPTH);

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_BLOCK = 2'd1;
  localparam logic [1:0] FUNC_TEXEL = 2'd2;

  typedef struct packed {
    logic [1:0]          func;
    logic [13:0]         table_addr;
    logic [7:0]          table_data;
    logic [CORNER_W-1:0] light_top_left;
    logic [CORNER_W-1:0] light_top_right;
    logic [CORNER_W-1:0] light_bottom_left;
    logic [CORNER_W-1:0] light_bottom_right;
    logic [7:0]          texel;
  } in_item_t;

  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [TABLE_AW-1:0] addr;
    logic [7:0]          wr_data;
  } ram_req_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic block_end;
  } rd_tag_t;

  typedef struct packed {
    logic [7:0] shaded_pixel;
    logic       row_end;
    logic       block_end;
  } out_item_t;

endpackage

@@ rtl/core/lts_shade_ram.sv @@
// single-port shade table memory with registered read data
module lts_shade_ram
  import lts_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [TABLE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lts_light_ctrl.sv @@
// light interpolation state, row/column counters and table request generation
module lts_light_ctrl
  import lts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  input  logic [1:0] mip,
  output ram_req_t req,
  output rd_tag_t  tag
);

  logic [LIGHT_W-1:0] edge_left_r, edge_left_nxt;
  logic [LIGHT_W-1:0] edge_right_r, edge_right_nxt;
  logic [LIGHT_W-1:0] el_step_r, el_step_nxt;
  logic [LIGHT_W-1:0] er_step_r, er_step_nxt;
  logic [LIGHT_W-1:0] light_r, light_nxt;
  logic [LIGHT_W-1:0] light_step_r, light_step_nxt;
  logic [3:0]         col_r, col_nxt;
  logic [3:0]         row_r, row_nxt;
  rd_tag_t            tag_r, tag_nxt;

  logic [2:0]           sh;
  logic [3:0]           last;
  logic signed [LIGHT_W:0] row_diff, row_sh;
  logic signed [CORNER_W:0] dl, dr, dt, dl_sh, dr_sh, dt_sh;
  logic [7:0]           lvl, lvl_sat;
  logic                 rend, bend;

  assign sh   = 3'd4 - {1'b0, mip};
  assign last = 4'd15 >> mip;

  // per-texel step from the current edges
  assign row_diff = {edge_right_r[LIGHT_W-1], edge_right_r}
                  - {edge_left_r[LIGHT_W-1], edge_left_r};
  assign row_sh   = row_diff >>> sh;

  // corner differences for a block start
  assign dl    = {1'b0, item.light_bottom_left} - {1'b0, item.light_top_left};
  assign dr    = {1'b0, item.light_bottom_right} - {1'b0, item.light_top_right};
  assign dt    = {1'b0, item.light_top_right} - {1'b0, item.light_top_left};
  assign dl_sh = dl >>> sh;
  assign dr_sh = dr >>> sh;
  assign dt_sh = dt >>> sh;

  // light level saturates at the top shade level
  assign lvl     = light_r[15:8];
  assign lvl_sat = (lvl > 8'(SHADE_LEVELS - 1)) ? 8'(SHADE_LEVELS - 1) : lvl;

  assign rend = col_r >= last;
  assign bend = rend && (row_r >= last);

  always_comb begin
    edge_left_nxt  = edge_left_r;
    edge_right_nxt = edge_right_r;
    el_step_nxt    = el_step_r;
    er_step_nxt    = er_step_r;
    light_nxt      = light_r;
    light_step_nxt = light_step_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    tag_nxt        = '0;
    req            = '0;
    if (accept) begin
      case (item.func)
        FUNC_WRITE: begin
          req.wr_en   = {18'd0, item.table_addr} < TABLE_DEPTH;
          req.addr    = TABLE_AW'(item.table_addr);
          req.wr_data = item.table_data;
        end
        FUNC_BLOCK: begin
          el_step_nxt    = {{(LIGHT_W-CORNER_W-1){dl_sh[CORNER_W]}}, dl_sh};
          er_step_nxt    = {{(LIGHT_W-CORNER_W-1){dr_sh[CORNER_W]}}, dr_sh};
          light_step_nxt = {{(LIGHT_W-CORNER_W-1){dt_sh[CORNER_W]}}, dt_sh};
          light_nxt      = LIGHT_W'(item.light_top_left);
          edge_left_nxt  = LIGHT_W'(item.light_top_left)
                         + {{(LIGHT_W-CORNER_W-1){dl_sh[CORNER_W]}}, dl_sh};
          edge_right_nxt = LIGHT_W'(item.light_top_right)
                         + {{(LIGHT_W-CORNER_W-1){dr_sh[CORNER_W]}}, dr_sh};
          col_nxt        = '0;
          row_nxt        = '0;
        end
        FUNC_TEXEL: begin
          req.rd_en         = 1'b1;
          req.addr          = {lvl_sat[LEVEL_W-1:0], item.texel};
          tag_nxt.valid     = 1'b1;
          tag_nxt.row_end   = rend;
          tag_nxt.block_end = bend;
          if (rend) begin
            col_nxt        = '0;
            row_nxt        = bend ? 4'd0 : row_r + 4'd1;
            light_step_nxt = row_sh[LIGHT_W-1:0];
            light_nxt      = edge_left_r;
            edge_left_nxt  = edge_left_r + el_step_r;
            edge_right_nxt = edge_right_r + er_step_r;
          end else begin
            col_nxt   = col_r + 4'd1;
            light_nxt = light_r + light_step_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_left_r  <= '0;
      edge_right_r <= '0;
      el_step_r    <= '0;
      er_step_r    <= '0;
      light_r      <= '0;
      light_step_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      tag_r        <= '0;
    end else begin
      edge_left_r  <= edge_left_nxt;
      edge_right_r <= edge_right_nxt;
      el_step_r    <= el_step_nxt;
      er_step_r    <= er_step_nxt;
      light_r      <= light_nxt;
      light_step_r <= light_step_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      tag_r        <= tag_nxt;
    end
  end

  assign tag = tag_r;

endmodule

@@ rtl/core/lts_out_fifo.sv @@
// small result queue that decouples the table read from the output handshake
module lts_out_fifo
  import lts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  out_item_t         push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output out_item_t         pop_item,
  output logic [OFIFO_AW:0] count
);

  out_item_t             entries [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OFIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OFIFO_AW:0]     cnt_r, cnt_nxt;
  logic                  pop;

  assign pop_valid = cnt_r != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = entries[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{OFIFO_AW{1'b0}}, push} - {{OFIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/lit_texture_block_shader_unit.sv @@
// top level of the lit texture block shader
//
// in_* channel: one request per item. in_tuser carries the function code
// (shade table write, block start with four corner lights, texel). table
// writes and block starts give no result; every texel gives one shaded pixel.
// out_* channel: shaded palette index in out_tdata, out_tlast on the last
// texel of a block row, out_tuser[0] on the last texel of the block.
// cfg_wr_en / cfg_wr_data set the mip level; write it only between blocks
// while nothing is in flight.
// a texel's table read and its tag are registered together; the result then
// passes the result queue to out_tvalid. throughput: one item per cycle while
// in_tready is high; each table write or texel makes one access to the
// single-port shade table memory, and the light update is one add.
// reset clears the light state, counters, mip level and result queue; the
// shade table is not cleared and must be written before it is read.
// a stalled receiver fills a four-entry result queue; in_tready drops once
// the queue plus the table read in flight fill it.
module lit_texture_block_shader_unit
  import lts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] table_addr, [21:14] table_data, [35:22] light_top_left,
  // [49:36] light_top_right, [63:50] light_bottom_left,
  // [77:64] light_bottom_right, [85:78] texel, [87:86] zero
  input  logic [87:0] in_tdata,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] shaded_pixel
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  // [0] block_end
  output logic [0:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  logic [1:0]          mip_r;
  in_item_t            item;
  ram_req_t            req;
  rd_tag_t             tag;
  logic [7:0]          rd_data;
  out_item_t           push_item, pop_item;
  logic [OFIFO_AW:0]   fifo_cnt;
  logic [OFIFO_AW+1:0] occupancy;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_r <= '0;
    end else if (cfg_wr_en) begin
      mip_r <= cfg_wr_data;
    end
  end

  assign item.func               = in_tuser;
  assign item.table_addr         = in_tdata[13:0];
  assign item.table_data         = in_tdata[21:14];
  assign item.light_top_left     = in_tdata[35:22];
  assign item.light_top_right    = in_tdata[49:36];
  assign item.light_bottom_left  = in_tdata[63:50];
  assign item.light_bottom_right = in_tdata[77:64];
  assign item.texel              = in_tdata[85:78];

  // room for the queue contents, the read in flight and one more request
  assign occupancy = {1'b0, fifo_cnt} + {{(OFIFO_AW+1){1'b0}}, tag.valid};
  assign in_tready = occupancy < (OFIFO_AW+2)'(OFIFO_DEPTH);
  assign accept    = in_tvalid && in_tready;

  lts_light_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .mip    (mip_r),
    .req    (req),
    .tag    (tag)
  );

  lts_shade_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign push_item.shaded_pixel = rd_data;
  assign push_item.row_end      = tag.row_end;
  assign push_item.block_end    = tag.block_end;

  lts_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tag.valid),
    .push_item (push_item),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_item  (pop_item),
    .count     (fifo_cnt)
  );

  assign out_tdata    = pop_item.shaded_pixel;
  assign out_tlast    = pop_item.row_end;
  assign out_tuser[0] = pop_item.block_end;

endmodule

@@ rtl/core/lts_checker.sv @@
// port-level checks for the lit texture block shader, bound to the top level
module lts_checker
  import lts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // block end always falls on a row end
  a_block_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("block end without row end");

  // an accepted texel is on offer once it has passed the table read and the result queue
  a_texel_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_TEXEL |-> ##2 out_tvalid)
    else $error("texel result missing");

endmodule

bind lit_texture_block_shader_unit lts_checker u_lts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
